FILE: src/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and constants for the bounded random range reducer.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int WORD_W    = 32;
    localparam int ST_W      = 2;
    localparam int DIV_STEPS = WORD_W;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_RANGE0  = 2'd2,
        ST_SRCFAIL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CL_ZERO = 2'd0,
        CL_FAIL = 2'd1,
        CL_POW2 = 2'd2,
        CL_MUL  = 2'd3
    } t_class;

    typedef struct packed {
        t_class              cls;
        logic [WORD_W-1:0]   word;
        logic [WORD_W-1:0]   bound;
    } t_item;

endpackage

FILE: src/bounded_random_range_reducer.sv
// ----------------------------------------------------------------------------
// bounded_random_range_reducer
// Maps a random word to a uniform value below a given range, or reports
// rejection, a zero range or a failed source.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | i_push / o_full        | i_range, i_random_word, i_source_failed
//  result   | o_empty / i_pop        | o_value, o_status
//
// One beat per cycle is accepted while not full; one result per beat, in order.
// A result reaches the result ports after passing through the input queue,
// the multiplier stage, the 32-stage remainder pipeline and the write into
// the result queue.
// Reset clears both queues and the pipeline valid bits.
// A full result queue stalls the pipeline, which then fills the input queue.
// ----------------------------------------------------------------------------
module bounded_random_range_reducer
    import brr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [WORD_W-1:0] i_range,
    input  logic [WORD_W-1:0] i_random_word,
    input  logic              i_source_failed,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [WORD_W-1:0] o_value,
    output logic [ST_W-1:0]   o_status
);

    t_item item;
    logic  avail;
    logic  take;

    brr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_range         (i_range),
        .i_random_word   (i_random_word),
        .i_source_failed (i_source_failed),
        .o_full          (o_full),
        .i_take          (take),
        .o_avail         (avail),
        .o_item          (item)
    );

    brr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .i_item   (item),
        .o_take   (take),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_value  (o_value),
        .o_status (o_status)
    );

`ifndef NO_ASSERTIONS
    a_nonok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != ST_OK) |-> (o_value == '0))
        else $error("non-accepted result carries a nonzero value");
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && ($past(i_rst_n) == 1'b0)) |-> (o_empty && !o_full))
        else $error("queues not empty after reset");
    a_take_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> avail)
        else $error("back end took from an empty queue");
`endif

endmodule

FILE: src/brr_front.sv
// ----------------------------------------------------------------------------
// brr_front
// Accepts input beats, classifies the range and holds items in a short queue.
// ----------------------------------------------------------------------------
module brr_front
    import brr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WORD_W-1:0] i_range,
    input  logic [WORD_W-1:0] i_random_word,
    input  logic              i_source_failed,
    output logic              o_full,
    input  logic              i_take,
    output logic              o_avail,
    output t_item             o_item
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    t_item             n_item;
    logic [WORD_W-1:0] range_m1;
    logic              push_ok;
    logic              take_ok;

    assign range_m1 = i_range - WORD_W'(1);
    assign o_full   = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_avail  = (r_cnt != '0);
    assign push_ok  = i_push && !o_full;
    assign take_ok  = i_take && o_avail;
    assign o_item   = r_mem[r_rp];

    always_comb begin
        n_item.bound = i_range;
        n_item.word  = i_random_word;
        priority if (i_range == '0) begin
            n_item.cls  = CL_ZERO;
            n_item.word = '0;
        end else if (i_source_failed) begin
            n_item.cls  = CL_FAIL;
            n_item.word = '0;
        end else if ((i_range & range_m1) == '0) begin
            n_item.cls  = CL_POW2;
            n_item.word = i_random_word & range_m1;
        end else begin
            n_item.cls  = CL_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (take_ok) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(push_ok) - (Q_AW+1)'(take_ok);
        end
    end

endmodule

FILE: src/brr_back.sv
// ----------------------------------------------------------------------------
// brr_back
// Multiplies, computes the rejection limit in a remainder pipeline with one
// bit per stage, decides the status and queues results for the consumer.
// ----------------------------------------------------------------------------
module brr_back
    import brr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  t_item             i_item,
    output logic              o_take,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [WORD_W-1:0] o_value,
    output logic [ST_W-1:0]   o_status
);

    logic              r_v   [DIV_STEPS+1];
    t_class            r_cls [DIV_STEPS+1];
    logic [WORD_W-1:0] r_hi  [DIV_STEPS+1];
    logic [WORD_W-1:0] r_lo  [DIV_STEPS+1];
    logic [WORD_W-1:0] r_bnd [DIV_STEPS+1];
    logic [WORD_W-1:0] r_rem [DIV_STEPS+1];
    logic [WORD_W-1:0] r_dvd [DIV_STEPS+1];
    logic [WORD_W-1:0] n_rem [DIV_STEPS+1];

    logic [WORD_W-1:0] r_oval [Q_DEPTH];
    t_status           r_ost  [Q_DEPTH];
    logic [Q_AW-1:0]   r_owp;
    logic [Q_AW-1:0]   r_orp;
    logic [Q_AW:0]     r_ocnt;

    logic [2*WORD_W-1:0] prod;
    logic [WORD_W:0]     trial [DIV_STEPS+1];
    logic                adv;
    logic                owr;
    logic                opop;
    logic [WORD_W-1:0]   n_oval;
    t_status             n_ost;
    logic [WORD_W-1:0]   last_lo;
    logic [WORD_W-1:0]   last_bnd;

    assign adv    = !(r_v[DIV_STEPS] && (r_ocnt == (Q_AW+1)'(Q_DEPTH)));
    assign o_take = i_avail && adv;
    assign owr    = r_v[DIV_STEPS] && adv;
    assign o_empty = (r_ocnt == '0);
    assign opop   = i_pop && !o_empty;
    assign o_value  = r_oval[r_orp];
    assign o_status = r_ost[r_orp];
    assign prod   = {{WORD_W{1'b0}}, i_item.word} * {{WORD_W{1'b0}}, i_item.bound};
    assign last_lo  = r_lo[DIV_STEPS];
    assign last_bnd = r_bnd[DIV_STEPS];

    always_comb begin
        trial[0] = '0;
        n_rem[0] = '0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial[k] = {r_rem[k-1], r_dvd[k-1][WORD_W-1]};
            if (trial[k] >= {1'b0, r_bnd[k-1]}) begin
                n_rem[k] = WORD_W'(trial[k] - {1'b0, r_bnd[k-1]});
            end else begin
                n_rem[k] = trial[k][WORD_W-1:0];
            end
        end
    end

    always_comb begin
        n_oval = r_hi[DIV_STEPS];
        unique case (r_cls[DIV_STEPS])
            CL_ZERO: n_ost = ST_RANGE0;
            CL_FAIL: n_ost = ST_SRCFAIL;
            CL_POW2: n_ost = ST_OK;
            CL_MUL: begin
                if ((last_lo < last_bnd) && (last_lo < r_rem[DIV_STEPS])) begin
                    n_ost  = ST_REJECT;
                    n_oval = '0;
                end else begin
                    n_ost  = ST_OK;
                end
            end
            default: n_ost = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cls[0] <= i_item.cls;
            r_bnd[0] <= i_item.bound;
            r_rem[0] <= '0;
            r_dvd[0] <= '0 - i_item.bound;
            if (i_item.cls == CL_MUL) begin
                r_hi[0] <= prod[2*WORD_W-1:WORD_W];
                r_lo[0] <= prod[WORD_W-1:0];
            end else begin
                r_hi[0] <= i_item.word;
                r_lo[0] <= '0;
            end
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_cls[k] <= r_cls[k-1];
                r_hi[k]  <= r_hi[k-1];
                r_lo[k]  <= r_lo[k-1];
                r_bnd[k] <= r_bnd[k-1];
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= {r_dvd[k-1][WORD_W-2:0], 1'b0};
            end
        end
        if (owr) begin
            r_oval[r_owp] <= n_oval;
            r_ost[r_owp]  <= n_ost;
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (adv) begin
                r_v[0] <= i_avail;
                for (int k = 1; k <= DIV_STEPS; k++) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (owr) begin
                r_owp <= r_owp + Q_AW'(1);
            end
            if (opop) begin
                r_orp <= r_orp + Q_AW'(1);
            end
            r_ocnt <= r_ocnt + (Q_AW+1)'(owr) - (Q_AW+1)'(opop);
        end
    end

endmodule
